/* src/ptco_pkg.sv */
// ----------------------------------------------------------------------------
// ptco_pkg
// Shared types and constants for the polar triangle origin test.
// ----------------------------------------------------------------------------
package ptco_pkg;

  // coordinate width: aligned radius is Q0.28, cordic gain stays below 2x
  localparam int unsigned CW = 31;
  // residual angle width in units of 2^-32 turn
  localparam int unsigned ZW = 33;
  // aligned radius width
  localparam int unsigned RW = 28;
  // product, numerator and denominator widths
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned DW = NW + 2;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // cartesian point out of one lane
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } point_t;

endpackage

/* src/ptco_cordic_lane.sv */
// ----------------------------------------------------------------------------
// ptco_cordic_lane
// Pipelined cordic rotation of one polar point, one stage per iteration.
// ----------------------------------------------------------------------------
module ptco_cordic_lane import ptco_pkg::*; #(
  parameter int unsigned RADIUS_BITS   = 16,
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic [RADIUS_BITS-1:0] radius_i,
  input  logic [ANGLE_BITS-1:0]  angle_i,
  output point_t                 point_o
);

  localparam logic [1:0] QUAD_POS_X = 2'd0;
  localparam logic [1:0] QUAD_POS_Y = 2'd1;
  localparam logic [1:0] QUAD_NEG_X = 2'd2;

  logic [RW-1:0]        r;
  logic [31:0]          a32;
  logic signed [CW-1:0] x_d;
  logic signed [CW-1:0] y_d;
  logic signed [CW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES];

  // align radius to q0.28
  if (RADIUS_BITS <= RW) begin : g_up
    assign r = RW'(radius_i) << (RW - RADIUS_BITS);
  end else begin : g_dn
    assign r = RW'(radius_i >> (RADIUS_BITS - RW));
  end

  // align angle to 32 bits of a turn
  assign a32 = 32'(angle_i) << (32 - ANGLE_BITS);

  // start vector from the quarter turn
  always_comb begin
    case (a32[31:30])
      QUAD_POS_X: begin
        x_d = CW'(signed'({1'b0, r}));
        y_d = '0;
      end
      QUAD_POS_Y: begin
        x_d = '0;
        y_d = CW'(signed'({1'b0, r}));
      end
      QUAD_NEG_X: begin
        x_d = -CW'(signed'({1'b0, r}));
        y_d = '0;
      end
      default: begin
        x_d = '0;
        y_d = -CW'(signed'({1'b0, r}));
      end
    endcase
  end

  // entry register
  always_ff @(posedge clk_i) begin
    x_q[0] <= x_d;
    y_q[0] <= y_d;
    z_q[0] <= signed'(ZW'(a32[29:0]));
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (!z_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
      end
    end
    if (i < CORDIC_STAGES - 1) begin : g_z
      logic signed [ZW-1:0] t;
      assign t = signed'(ZW'(ATAN_TURN[i]));
      always_ff @(posedge clk_i) begin
        z_q[i+1] <= z_q[i][ZW-1] ? z_q[i] + t : z_q[i] - t;
      end
    end
  end

  assign point_o.x = x_q[CORDIC_STAGES];
  assign point_o.y = y_q[CORDIC_STAGES];

endmodule

/* src/ptco_merge.sv */
// ----------------------------------------------------------------------------
// ptco_merge
// Cross products of the three lane points and the sign agreement test.
// ----------------------------------------------------------------------------
module ptco_merge import ptco_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  point_t pa_i,
  input  point_t pb_i,
  input  point_t pc_i,
  output logic   done_o,
  output logic   contains_origin_o,
  output logic   degenerate_o
);

  logic signed [PW-1:0] bxcy_q, bycx_q, aycx_q, axcy_q, axby_q, aybx_q;
  logic signed [NW-1:0] n1_q, n2_q, n3_q;
  logic signed [DW-1:0] den;
  logic                 den_pos, den_nz, in1, in2, in3;
  logic [1:0]           vld_q;

  // products
  always_ff @(posedge clk_i) begin
    bxcy_q <= pb_i.x * pc_i.y;
    bycx_q <= pb_i.y * pc_i.x;
    aycx_q <= pa_i.y * pc_i.x;
    axcy_q <= pa_i.x * pc_i.y;
    axby_q <= pa_i.x * pb_i.y;
    aybx_q <= pa_i.y * pb_i.x;
  end

  // numerators for the origin
  always_ff @(posedge clk_i) begin
    n1_q <= NW'(bxcy_q) - NW'(bycx_q);
    n2_q <= NW'(aycx_q) - NW'(axcy_q);
    n3_q <= NW'(axby_q) - NW'(aybx_q);
  end

  // denominator and sign agreement
  always_comb begin
    den     = DW'(n1_q) + DW'(n2_q) + DW'(n3_q);
    den_nz  = (den != '0);
    den_pos = den_nz && !den[DW-1];
    in1     = (n1_q == '0) || ((!n1_q[NW-1]) == den_pos);
    in2     = (n2_q == '0) || ((!n2_q[NW-1]) == den_pos);
    in3     = (n3_q == '0) || ((!n3_q[NW-1]) == den_pos);
  end

  // result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[0], valid_i};
      done_o <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    contains_origin_o <= den_nz && in1 && in2 && in3;
    degenerate_o      <= !den_nz;
  end

endmodule

/* src/polar_triangle_contains_origin.sv */
// ----------------------------------------------------------------------------
// polar_triangle_contains_origin
// Converts three polar points with cordic lanes and tests the origin.
// ----------------------------------------------------------------------------
// done_o follows start through the lane registers and the merge registers
// throughput: one request per cycle, set by the fully pipelined cordic lanes
// busy is always low; results cannot be stalled
// reset clears only the valid pipeline; data registers are not reset
module polar_triangle_contains_origin import ptco_pkg::*; #(
  parameter int unsigned RADIUS_BITS   = 16,
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [RADIUS_BITS-1:0] radius_a_i,
  input  logic [ANGLE_BITS-1:0]  angle_a_i,
  input  logic [RADIUS_BITS-1:0] radius_b_i,
  input  logic [ANGLE_BITS-1:0]  angle_b_i,
  input  logic [RADIUS_BITS-1:0] radius_c_i,
  input  logic [ANGLE_BITS-1:0]  angle_c_i,
  output logic                   done_o,
  output logic                   contains_origin_o,
  output logic                   degenerate_o
);

  point_t                   pa, pb, pc;
  logic [CORDIC_STAGES:0]   vld_q;

  assign busy = 1'b0;

  // request valid follows the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CORDIC_STAGES-1:0], start && !busy};
    end
  end

  ptco_cordic_lane #(
    .RADIUS_BITS(RADIUS_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_lane_a (
    .clk_i(clk_i), .radius_i(radius_a_i), .angle_i(angle_a_i), .point_o(pa)
  );

  ptco_cordic_lane #(
    .RADIUS_BITS(RADIUS_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_lane_b (
    .clk_i(clk_i), .radius_i(radius_b_i), .angle_i(angle_b_i), .point_o(pb)
  );

  ptco_cordic_lane #(
    .RADIUS_BITS(RADIUS_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_lane_c (
    .clk_i(clk_i), .radius_i(radius_c_i), .angle_i(angle_c_i), .point_o(pc)
  );

  ptco_merge u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (vld_q[CORDIC_STAGES]),
    .pa_i              (pa),
    .pb_i              (pb),
    .pc_i              (pc),
    .done_o            (done_o),
    .contains_origin_o (contains_origin_o),
    .degenerate_o      (degenerate_o)
  );

endmodule
